// ----- sv/rie_pkg.sv -----
// ---------------------------------------------------------------------------
// rie_pkg
// Opcodes, fault codes and address map for the immediate execute unit.
// ---------------------------------------------------------------------------
package rie_pkg;

    localparam logic [5:0] OP_REGIMM = 6'h01;
    localparam logic [5:0] OP_BEQ    = 6'h04;
    localparam logic [5:0] OP_BNE    = 6'h05;
    localparam logic [5:0] OP_BLEZ   = 6'h06;
    localparam logic [5:0] OP_BGTZ   = 6'h07;
    localparam logic [5:0] OP_ADDI   = 6'h08;
    localparam logic [5:0] OP_ADDIU  = 6'h09;
    localparam logic [5:0] OP_SLTI   = 6'h0A;
    localparam logic [5:0] OP_SLTIU  = 6'h0B;
    localparam logic [5:0] OP_ANDI   = 6'h0C;
    localparam logic [5:0] OP_ORI    = 6'h0D;
    localparam logic [5:0] OP_XORI   = 6'h0E;
    localparam logic [5:0] OP_LUI    = 6'h0F;
    localparam logic [5:0] OP_LB     = 6'h20;
    localparam logic [5:0] OP_LH     = 6'h21;
    localparam logic [5:0] OP_LWL    = 6'h22;
    localparam logic [5:0] OP_LW     = 6'h23;
    localparam logic [5:0] OP_LBU    = 6'h24;
    localparam logic [5:0] OP_LHU    = 6'h25;
    localparam logic [5:0] OP_LWR    = 6'h26;
    localparam logic [5:0] OP_SB     = 6'h28;
    localparam logic [5:0] OP_SH     = 6'h29;
    localparam logic [5:0] OP_SW     = 6'h2B;

    // REGIMM sub-codes carried in rt
    localparam logic [4:0] RT_BLTZ   = 5'b00000;
    localparam logic [4:0] RT_BGEZ   = 5'b00001;
    localparam logic [4:0] RT_BLTZAL = 5'b10000;
    localparam logic [4:0] RT_BGEZAL = 5'b10001;

    localparam logic [4:0] LINK_REG  = 5'd31;

    // readable regions, tested on the word address
    localparam logic [5:0]  RAM_HI_BITS  = 6'b001000;     // 0x2000_0000..0x23FF_FFFF
    localparam logic [7:0]  ROM_HI_BITS  = 8'h10;         // 0x1000_0000..0x10FF_FFFF
    localparam logic [29:0] IO_WORD_ADDR = 30'h0C00_0000; // 0x3000_0000

    typedef enum logic [2:0] {
        FAULT_NONE     = 3'd0,
        FAULT_OVERFLOW = 3'd1,
        FAULT_ALIGN    = 3'd2,
        FAULT_RANGE    = 3'd3,
        FAULT_UNKNOWN  = 3'd4,
        FAULT_RESERVED = 3'd5
    } fault_t;

endpackage

// ----- sv/risc_immediate_execute_unit.sv -----
// ---------------------------------------------------------------------------
// risc_immediate_execute_unit
// Three-stage execute unit for immediate-format instructions.
// ---------------------------------------------------------------------------
//
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+----------------------------------
//  command  | in        | start / busy        | instr_word, src_value, tgt_value,
//           |           |                     | slot_pc, load_word
//  result   | out       | done (one-cycle)    | wb_*, store_enable, mem_addr,
//           |           |                     | store_data, byte_mask, branch_*,
//           |           |                     | fault_code
//
//  A command passes through the stage 1, stage 2 and stage 3 registers; done
//  and the result ports are driven from the stage 3 registers.
//  One command is taken every cycle; busy stays low, as nothing downstream
//  can hold the pipe.
//  Stage 1 holds the three 32-bit adders (address, branch target, link) and
//  the compares; stage 2 decodes, checks and steers lanes; stage 3 applies the
//  fault rules into the output registers.
//  Reset clears the valid bits only; nothing is lost or repeated since there
//  is no stall path.
//
module risc_immediate_execute_unit
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [31:0]          instr_word,
    input  logic [31:0]          src_value,
    input  logic [31:0]          tgt_value,
    input  logic [31:0]          slot_pc,
    input  logic [31:0]          load_word,
    output logic                 done,
    output logic                 wb_enable,
    output logic [4:0]           wb_index,
    output logic [31:0]          wb_value,
    output logic                 store_enable,
    output logic [31:0]          mem_addr,
    output logic [31:0]          store_data,
    output logic [3:0]           byte_mask,
    output logic                 branch_taken,
    output logic [31:0]          branch_target,
    output logic [2:0]           fault_code
);
    import rie_pkg::*;

    // -----------------------------------------------------------------------
    // Stage 1: operand capture, adders and compares
    // -----------------------------------------------------------------------
    logic        s1_valid_reg;
    logic [5:0]  s1_op_reg;
    logic [4:0]  s1_rt_reg;
    logic        s1_rs_nz_reg;
    logic [15:0] s1_imm_reg;
    logic [31:0] s1_sv_reg;
    logic [31:0] s1_tv_reg;
    logic [31:0] s1_mw_reg;
    logic [31:0] s1_ea_reg;
    logic [31:0] s1_tgt_reg;
    logic [31:0] s1_link_reg;
    logic        s1_ovf_reg;
    logic        s1_lt_s_reg;
    logic        s1_lt_u_reg;
    logic        s1_eq_reg;
    logic        s1_sv_zero_reg;

    logic [31:0] simm_next;
    logic [31:0] ea_next;
    logic        ovf_next;

    assign busy = 1'b0;

    always_comb
    begin
        simm_next = {{16{instr_word[15]}}, instr_word[15:0]};
        ea_next   = src_value + simm_next;
        ovf_next  = (~(src_value[31] ^ simm_next[31])) & (src_value[31] ^ ea_next[31]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_op_reg      <= instr_word[31:26];
        s1_rt_reg      <= instr_word[20:16];
        s1_rs_nz_reg   <= |instr_word[25:21];
        s1_imm_reg     <= instr_word[15:0];
        s1_sv_reg      <= src_value;
        s1_tv_reg      <= tgt_value;
        s1_mw_reg      <= load_word;
        s1_ea_reg      <= ea_next;
        s1_tgt_reg     <= slot_pc + {simm_next[29:0], 2'b00};
        s1_link_reg    <= slot_pc + 32'd4;
        s1_ovf_reg     <= ovf_next;
        s1_lt_s_reg    <= $signed(src_value) < $signed(simm_next);
        s1_lt_u_reg    <= src_value < simm_next;
        s1_eq_reg      <= src_value == tgt_value;
        s1_sv_zero_reg <= src_value == 32'd0;
    end

    // -----------------------------------------------------------------------
    // Stage 2: decode, alignment and region checks, lane steering
    // -----------------------------------------------------------------------
    logic        s2_valid_reg;
    logic        s2_wbe_reg;
    logic [4:0]  s2_wbi_reg;
    logic [31:0] s2_wbv_reg;
    logic        s2_ste_reg;
    logic [31:0] s2_maddr_reg;
    logic [31:0] s2_sdata_reg;
    logic [3:0]  s2_mask_reg;
    logic        s2_taken_reg;
    logic [31:0] s2_btgt_reg;
    fault_t      s2_fault_reg;

    logic        s2_wbe_next;
    logic [4:0]  s2_wbi_next;
    logic [31:0] s2_wbv_next;
    logic        s2_ste_next;
    logic [31:0] s2_maddr_next;
    logic [31:0] s2_sdata_next;
    logic [3:0]  s2_mask_next;
    logic        s2_taken_next;
    logic [31:0] s2_btgt_next;
    fault_t      s2_fault_next;
    logic        is_load;
    logic        is_link;
    logic        readable;
    logic [1:0]  lane;
    logic [7:0]  ld_byte;
    logic [15:0] ld_half;
    logic [31:0] ld_value;

    always_comb
    begin
        lane     = s1_ea_reg[1:0];
        readable = (s1_ea_reg[31:26] == RAM_HI_BITS) ||
                   (s1_ea_reg[31:24] == ROM_HI_BITS) ||
                   (s1_ea_reg[31:2] == IO_WORD_ADDR);

        case (lane)
            2'd0:    ld_byte = s1_mw_reg[31:24];
            2'd1:    ld_byte = s1_mw_reg[23:16];
            2'd2:    ld_byte = s1_mw_reg[15:8];
            default: ld_byte = s1_mw_reg[7:0];
        endcase
        ld_half = (lane != 2'd0) ? s1_mw_reg[15:0] : s1_mw_reg[31:16];

        case (s1_op_reg)
            OP_LB:   ld_value = {{24{ld_byte[7]}}, ld_byte};
            OP_LBU:  ld_value = {24'd0, ld_byte};
            OP_LH:   ld_value = {{16{ld_half[15]}}, ld_half};
            OP_LHU:  ld_value = {16'd0, ld_half};
            OP_LWL:
            begin
                case (lane)
                    2'd0:    ld_value = s1_mw_reg;
                    2'd1:    ld_value = {s1_mw_reg[23:0], s1_tv_reg[7:0]};
                    2'd2:    ld_value = {s1_mw_reg[15:0], s1_tv_reg[15:0]};
                    default: ld_value = {s1_mw_reg[7:0], s1_tv_reg[23:0]};
                endcase
            end
            OP_LWR:
            begin
                case (lane)
                    2'd0:    ld_value = {s1_tv_reg[31:8], s1_mw_reg[31:24]};
                    2'd1:    ld_value = {s1_tv_reg[31:16], s1_mw_reg[31:16]};
                    2'd2:    ld_value = {s1_tv_reg[31:24], s1_mw_reg[31:8]};
                    default: ld_value = s1_mw_reg;
                endcase
            end
            default: ld_value = s1_mw_reg;
        endcase
    end

    always_comb
    begin
        s2_wbe_next   = 1'b0;
        s2_wbv_next   = 32'd0;
        s2_ste_next   = 1'b0;
        s2_maddr_next = 32'd0;
        s2_sdata_next = 32'd0;
        s2_mask_next  = 4'd0;
        s2_taken_next = 1'b0;
        s2_btgt_next  = 32'd0;
        s2_fault_next = FAULT_NONE;
        is_load       = 1'b0;
        is_link       = 1'b0;

        case (s1_op_reg)
            OP_ANDI:
            begin
                s2_wbe_next = 1'b1;
                s2_wbv_next = s1_sv_reg & {16'd0, s1_imm_reg};
            end
            OP_ORI:
            begin
                s2_wbe_next = 1'b1;
                s2_wbv_next = s1_sv_reg | {16'd0, s1_imm_reg};
            end
            OP_XORI:
            begin
                s2_wbe_next = 1'b1;
                s2_wbv_next = s1_sv_reg ^ {16'd0, s1_imm_reg};
            end
            OP_SLTI:
            begin
                s2_wbe_next = 1'b1;
                s2_wbv_next = {31'd0, s1_lt_s_reg};
            end
            OP_SLTIU:
            begin
                s2_wbe_next = 1'b1;
                s2_wbv_next = {31'd0, s1_lt_u_reg};
            end
            OP_ADDI:
            begin
                s2_wbv_next = s1_ea_reg;
                if (s1_ovf_reg)
                begin
                    s2_fault_next = FAULT_OVERFLOW;
                end
                else
                begin
                    s2_wbe_next = 1'b1;
                end
            end
            OP_ADDIU:
            begin
                s2_wbe_next = 1'b1;
                s2_wbv_next = s1_ea_reg;
            end
            OP_LUI:
            begin
                if (s1_rs_nz_reg)
                begin
                    s2_fault_next = FAULT_RESERVED;
                end
                else
                begin
                    s2_wbe_next = 1'b1;
                    s2_wbv_next = {s1_imm_reg, 16'd0};
                end
            end
            OP_BEQ:
            begin
                s2_btgt_next  = s1_tgt_reg;
                s2_taken_next = s1_eq_reg;
            end
            OP_BNE:
            begin
                s2_btgt_next  = s1_tgt_reg;
                s2_taken_next = !s1_eq_reg;
            end
            OP_BGTZ:
            begin
                s2_btgt_next = s1_tgt_reg;
                if (s1_rt_reg != 5'd0)
                begin
                    s2_fault_next = FAULT_RESERVED;
                end
                else
                begin
                    s2_taken_next = !s1_sv_reg[31] && !s1_sv_zero_reg;
                end
            end
            OP_BLEZ:
            begin
                s2_btgt_next = s1_tgt_reg;
                if (s1_rt_reg != 5'd0)
                begin
                    s2_fault_next = FAULT_RESERVED;
                end
                else
                begin
                    s2_taken_next = s1_sv_reg[31] || s1_sv_zero_reg;
                end
            end
            OP_REGIMM:
            begin
                if (s1_rt_reg == RT_BLTZ || s1_rt_reg == RT_BLTZAL ||
                    s1_rt_reg == RT_BGEZ || s1_rt_reg == RT_BGEZAL)
                begin
                    s2_btgt_next = s1_tgt_reg;
                    // rt bit 0 selects the >= 0 test, bit 4 the link form
                    s2_taken_next = s1_rt_reg[0] ? !s1_sv_reg[31] : s1_sv_reg[31];
                    if (s1_rt_reg[4])
                    begin
                        is_link     = 1'b1;
                        s2_wbe_next = 1'b1;
                        s2_wbv_next = s1_link_reg;
                    end
                end
                else
                begin
                    s2_fault_next = FAULT_UNKNOWN;
                end
            end
            OP_SB:
            begin
                s2_maddr_next = s1_ea_reg;
                s2_ste_next   = 1'b1;
                case (lane)
                    2'd0:
                    begin
                        s2_sdata_next = {s1_tv_reg[7:0], 24'd0};
                        s2_mask_next  = 4'b1000;
                    end
                    2'd1:
                    begin
                        s2_sdata_next = {8'd0, s1_tv_reg[7:0], 16'd0};
                        s2_mask_next  = 4'b0100;
                    end
                    2'd2:
                    begin
                        s2_sdata_next = {16'd0, s1_tv_reg[7:0], 8'd0};
                        s2_mask_next  = 4'b0010;
                    end
                    default:
                    begin
                        s2_sdata_next = {24'd0, s1_tv_reg[7:0]};
                        s2_mask_next  = 4'b0001;
                    end
                endcase
            end
            OP_SH:
            begin
                s2_maddr_next = s1_ea_reg;
                if (lane[0])
                begin
                    s2_fault_next = FAULT_ALIGN;
                end
                else
                begin
                    s2_ste_next = 1'b1;
                    if (lane == 2'd0)
                    begin
                        s2_sdata_next = {s1_tv_reg[15:0], 16'd0};
                        s2_mask_next  = 4'b1100;
                    end
                    else
                    begin
                        s2_sdata_next = {16'd0, s1_tv_reg[15:0]};
                        s2_mask_next  = 4'b0011;
                    end
                end
            end
            OP_SW:
            begin
                s2_maddr_next = s1_ea_reg;
                if (lane != 2'd0)
                begin
                    s2_fault_next = FAULT_ALIGN;
                end
                else
                begin
                    s2_ste_next   = 1'b1;
                    s2_sdata_next = s1_tv_reg;
                    s2_mask_next  = 4'b1111;
                end
            end
            OP_LB, OP_LBU, OP_LWL, OP_LWR:
            begin
                is_load       = 1'b1;
                s2_maddr_next = s1_ea_reg;
            end
            OP_LH, OP_LHU:
            begin
                is_load       = 1'b1;
                s2_maddr_next = s1_ea_reg;
                if (lane[0])
                begin
                    s2_fault_next = FAULT_ALIGN;
                end
            end
            OP_LW:
            begin
                is_load       = 1'b1;
                s2_maddr_next = s1_ea_reg;
                if (lane != 2'd0)
                begin
                    s2_fault_next = FAULT_ALIGN;
                end
            end
            default:
            begin
                s2_fault_next = FAULT_UNKNOWN;
            end
        endcase

        // alignment first, then the region check
        if (is_load && s2_fault_next == FAULT_NONE)
        begin
            if (!readable)
            begin
                s2_fault_next = FAULT_RANGE;
            end
            else
            begin
                s2_wbe_next = 1'b1;
                s2_wbv_next = ld_value;
            end
        end

        s2_wbi_next = is_link ? LINK_REG : s1_rt_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_wbe_reg   <= s2_wbe_next;
        s2_wbi_reg   <= s2_wbi_next;
        s2_wbv_reg   <= s2_wbv_next;
        s2_ste_reg   <= s2_ste_next;
        s2_maddr_reg <= s2_maddr_next;
        s2_sdata_reg <= s2_sdata_next;
        s2_mask_reg  <= s2_mask_next;
        s2_taken_reg <= s2_taken_next;
        s2_btgt_reg  <= s2_btgt_next;
        s2_fault_reg <= s2_fault_next;
    end

    // -----------------------------------------------------------------------
    // Stage 3: fault squash and zeroing of unused fields
    // -----------------------------------------------------------------------
    logic        done_reg;
    logic        wbe_reg;
    logic [4:0]  wbi_reg;
    logic [31:0] wbv_reg;
    logic        ste_reg;
    logic [31:0] maddr_reg;
    logic [31:0] sdata_reg;
    logic [3:0]  mask_reg;
    logic        taken_reg;
    logic [31:0] btgt_reg;
    fault_t      fault_reg;

    logic        ok;
    logic        wbe_next;

    always_comb
    begin
        ok       = s2_fault_reg == FAULT_NONE;
        wbe_next = ok && s2_wbe_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        wbe_reg   <= wbe_next;
        wbi_reg   <= wbe_next ? s2_wbi_reg : 5'd0;
        wbv_reg   <= wbe_next ? s2_wbv_reg : 32'd0;
        ste_reg   <= ok && s2_ste_reg;
        sdata_reg <= ok ? s2_sdata_reg : 32'd0;
        mask_reg  <= ok ? s2_mask_reg : 4'd0;
        taken_reg <= ok && s2_taken_reg;
        maddr_reg <= s2_maddr_reg;
        btgt_reg  <= s2_btgt_reg;
        fault_reg <= s2_fault_reg;
    end

    assign done          = done_reg;
    assign wb_enable     = wbe_reg;
    assign wb_index      = wbi_reg;
    assign wb_value      = wbv_reg;
    assign store_enable  = ste_reg;
    assign mem_addr      = maddr_reg;
    assign store_data    = sdata_reg;
    assign byte_mask     = mask_reg;
    assign branch_taken  = taken_reg;
    assign branch_target = btgt_reg;
    assign fault_code    = fault_reg;

    // -----------------------------------------------------------------------
    // Assertions
    // -----------------------------------------------------------------------
    a_fault_squash: assert property (@(posedge clk) disable iff (!rst_n)
        done && fault_code != FAULT_NONE |-> !wb_enable && !store_enable && !branch_taken)
        else $error("faulted result still writes, stores or branches");

    a_store_lanes: assert property (@(posedge clk) disable iff (!rst_n)
        done && store_enable |-> byte_mask != 4'd0 && !wb_enable)
        else $error("store issued with no byte lanes or with a writeback");

    a_pipe_flow: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |=> ##1 done)
        else $error("item lost between stage one and the result");

    a_link_index: assert property (@(posedge clk) disable iff (!rst_n)
        done && wb_enable && !store_enable && wb_index == LINK_REG && !$past(is_link, 2)
            |-> $past(s1_rt_reg, 2) == LINK_REG)
        else $error("link register written by a non-linking instruction");

endmodule

// ----- dv/tb_risc_immediate_execute_unit.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_risc_immediate_execute_unit
// Self-checking bench for the immediate-format execute unit: a directed table
// of corner instructions, then about a thousand random ones weighted towards
// readable loads and well-formed branches, scored by the model unless pinned.
// ---------------------------------------------------------------------------
module tb_risc_immediate_execute_unit;

    import rie_pkg::*;

    // Opcode and REGIMM sub-code that the unit does not implement
    localparam logic [5:0]  OP_UNUSED  = 6'h3F;
    localparam logic [4:0]  RT_UNUSED  = 5'b00010;

    // Readable address map, on the word address
    localparam logic [31:0] RAM_LO     = 32'h2000_0000;
    localparam logic [31:0] RAM_HI     = 32'h2400_0000;
    localparam logic [31:0] ROM_LO     = 32'h1000_0000;
    localparam logic [31:0] ROM_HI     = 32'h1100_0000;
    localparam logic [31:0] IO_WORD    = 32'h3000_0000;

    localparam int RANDOM_ITEMS = 1000;
    localparam int DRAIN_LIMIT  = 100;  // cycles allowed for the pipe to empty
    localparam int TAIL_CYCLES  = 8;    // pipe is three deep

    // One instruction with its operands, in port order
    typedef struct packed {
        logic [31:0] instr;
        logic [31:0] src;
        logic [31:0] tgt;
        logic [31:0] pc;
        logic [31:0] ldw;
    } cmd_t;

    // Everything the unit reports for one instruction
    typedef struct packed {
        logic        wb_en;
        logic [4:0]  wb_idx;
        logic [31:0] wb_val;
        logic        st_en;
        logic [31:0] addr;
        logic [31:0] st_data;
        logic [3:0]  mask;
        logic        taken;
        logic [31:0] target;
        fault_t      fault;
    } exec_res_t;

    // Directed row; pinned rows carry a hand-written result
    typedef struct packed {
        cmd_t      cmd;
        logic      pinned;
        exec_res_t want;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [31:0] instr_word;
    logic [31:0] src_value;
    logic [31:0] tgt_value;
    logic [31:0] slot_pc;
    logic [31:0] load_word;
    logic        done;
    logic        wb_enable;
    logic [4:0]  wb_index;
    logic [31:0] wb_value;
    logic        store_enable;
    logic [31:0] mem_addr;
    logic [31:0] store_data;
    logic [3:0]  byte_mask;
    logic        branch_taken;
    logic [31:0] branch_target;
    logic [2:0]  fault_code;

    // Hand-written expectation travelling alongside the current command
    logic        pin_valid;
    exec_res_t   pin_res;

    exec_res_t   pending_results[$];
    dir_row_t    stimulus_table[$];
    logic [5:0]  known_ops [23];
    int          sender_idle_pct;
    int          error_count;
    int          results_seen;

    risc_immediate_execute_unit i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .instr_word    (instr_word),
        .src_value     (src_value),
        .tgt_value     (tgt_value),
        .slot_pc       (slot_pc),
        .load_word     (load_word),
        .done          (done),
        .wb_enable     (wb_enable),
        .wb_index      (wb_index),
        .wb_value      (wb_value),
        .store_enable  (store_enable),
        .mem_addr      (mem_addr),
        .store_data    (store_data),
        .byte_mask     (byte_mask),
        .branch_taken  (branch_taken),
        .branch_target (branch_target),
        .fault_code    (fault_code)
    );

    // 8 ns period
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // -----------------------------------------------------------------------
    // Model of the unit: one instruction in, one result out, no state.
    // -----------------------------------------------------------------------
    function automatic exec_res_t execute_immediate(input cmd_t c);
        exec_res_t   r;
        logic [5:0]  op;
        logic [4:0]  rs;
        logic [4:0]  rt;
        logic [15:0] imm;
        logic [31:0] simm;
        logic [31:0] ea;
        logic [31:0] sum;
        logic [31:0] target;
        logic [31:0] word_addr;
        logic [31:0] lane_byte;
        logic [15:0] lane_half;
        logic [1:0]  align;
        logic        is_load;
        logic        link;
        int unsigned lane;
        int unsigned sh;
        fault_t      fault;

        op      = c.instr[31:26];
        rs      = c.instr[25:21];
        rt      = c.instr[20:16];
        imm     = c.instr[15:0];
        simm    = {{16{imm[15]}}, imm};
        ea      = c.src + simm;
        sum     = c.src + simm;
        target  = c.pc + (simm << 2);
        lane    = 32'(ea[1:0]);
        r       = '0;
        fault   = FAULT_NONE;
        align   = 2'b00;
        is_load = 1'b0;
        link    = 1'b0;

        case (op)
            OP_ANDI:
            begin
                r.wb_en  = 1'b1;
                r.wb_val = c.src & {16'h0000, imm};
            end
            OP_ORI:
            begin
                r.wb_en  = 1'b1;
                r.wb_val = c.src | {16'h0000, imm};
            end
            OP_XORI:
            begin
                r.wb_en  = 1'b1;
                r.wb_val = c.src ^ {16'h0000, imm};
            end
            OP_SLTI:
            begin
                r.wb_en  = 1'b1;
                r.wb_val = {31'd0, $signed(c.src) < $signed(simm)};
            end
            OP_SLTIU:
            begin
                r.wb_en  = 1'b1;
                r.wb_val = {31'd0, c.src < simm};
            end
            OP_ADDI:
            begin
                // trap when both operands agree in sign and the sum does not
                r.wb_val = sum;
                if (!(c.src[31] ^ simm[31]) && (c.src[31] ^ sum[31]))
                    fault = FAULT_OVERFLOW;
                else
                    r.wb_en = 1'b1;
            end
            OP_ADDIU:
            begin
                r.wb_en  = 1'b1;
                r.wb_val = sum;
            end
            OP_LUI:
            begin
                if (rs != 5'd0)
                    fault = FAULT_RESERVED;
                else
                begin
                    r.wb_en  = 1'b1;
                    r.wb_val = {imm, 16'h0000};
                end
            end
            OP_BEQ:
            begin
                r.target = target;
                r.taken  = (c.src == c.tgt);
            end
            OP_BNE:
            begin
                r.target = target;
                r.taken  = (c.src != c.tgt);
            end
            OP_BGTZ:
            begin
                r.target = target;
                if (rt != 5'd0)
                    fault = FAULT_RESERVED;
                else
                    r.taken = !c.src[31] && (c.src != 32'd0);
            end
            OP_BLEZ:
            begin
                r.target = target;
                if (rt != 5'd0)
                    fault = FAULT_RESERVED;
                else
                    r.taken = c.src[31] || (c.src == 32'd0);
            end
            OP_REGIMM:
            begin
                case (rt)
                    RT_BGEZ, RT_BGEZAL: r.taken = !c.src[31];
                    RT_BLTZ, RT_BLTZAL: r.taken = c.src[31];
                    default:            fault   = FAULT_UNKNOWN;
                endcase
                if (fault == FAULT_NONE)
                begin
                    r.target = target;
                    // linking forms write the return address taken or not
                    if (rt == RT_BGEZAL || rt == RT_BLTZAL)
                    begin
                        link     = 1'b1;
                        r.wb_en  = 1'b1;
                        r.wb_val = c.pc + 32'd4;
                    end
                end
            end
            OP_SB, OP_SH, OP_SW:
            begin
                r.addr = ea;
                align  = (op == OP_SB) ? 2'b00 : (op == OP_SH) ? 2'b01 : 2'b11;
                if ((ea[1:0] & align) != 2'b00)
                    fault = FAULT_ALIGN;
                else
                begin
                    r.st_en = 1'b1;
                    if (op == OP_SB)
                    begin
                        r.st_data = {24'h0, c.tgt[7:0]} << (8 * (3 - lane));
                        r.mask    = 4'b0001 << (3 - lane);
                    end
                    else if (op == OP_SH)
                    begin
                        r.st_data = (lane == 0) ? {c.tgt[15:0], 16'h0000}
                                                : {16'h0000, c.tgt[15:0]};
                        r.mask    = (lane == 0) ? 4'b1100 : 4'b0011;
                    end
                    else
                    begin
                        r.st_data = c.tgt;
                        r.mask    = 4'b1111;
                    end
                end
            end
            OP_LB, OP_LBU, OP_LH, OP_LHU, OP_LW, OP_LWL, OP_LWR:
            begin
                is_load = 1'b1;
                r.addr  = ea;
                align   = (op == OP_LH || op == OP_LHU) ? 2'b01 :
                          (op == OP_LW) ? 2'b11 : 2'b00;
            end
            default:
                fault = FAULT_UNKNOWN;
        endcase

        if (is_load)
        begin
            word_addr = {ea[31:2], 2'b00};
            lane_byte = c.ldw >> (8 * (3 - lane));
            lane_half = (lane != 0) ? c.ldw[15:0] : c.ldw[31:16];
            // alignment takes precedence over the region check
            if ((ea[1:0] & align) != 2'b00)
                fault = FAULT_ALIGN;
            else if (!((word_addr >= RAM_LO && word_addr < RAM_HI) ||
                       (word_addr >= ROM_LO && word_addr < ROM_HI) ||
                       (word_addr == IO_WORD)))
                fault = FAULT_RANGE;
            else
            begin
                r.wb_en = 1'b1;
                case (op)
                    OP_LB:  r.wb_val = {{24{lane_byte[7]}}, lane_byte[7:0]};
                    OP_LBU: r.wb_val = {24'h0, lane_byte[7:0]};
                    OP_LH:  r.wb_val = {{16{lane_half[15]}}, lane_half};
                    OP_LHU: r.wb_val = {16'h0000, lane_half};
                    OP_LW:  r.wb_val = c.ldw;
                    OP_LWL:
                    begin
                        sh       = 8 * lane;
                        r.wb_val = (c.ldw << sh) | (c.tgt & ((32'd1 << sh) - 32'd1));
                    end
                    default:
                    begin
                        sh       = 8 * (3 - lane);
                        r.wb_val = (c.ldw >> sh) | (c.tgt & ~(32'hFFFF_FFFF >> sh));
                    end
                endcase
            end
        end

        if (r.wb_en)
            r.wb_idx = link ? LINK_REG : rt;

        if (fault != FAULT_NONE)
        begin
            r.wb_en   = 1'b0;
            r.wb_idx  = 5'd0;
            r.wb_val  = 32'd0;
            r.st_en   = 1'b0;
            r.st_data = 32'd0;
            r.mask    = 4'd0;
            r.taken   = 1'b0;
            if (fault == FAULT_UNKNOWN)
            begin
                r.addr   = 32'd0;
                r.target = 32'd0;
            end
        end
        r.fault = fault;
        return r;
    endfunction

    function automatic logic [31:0] enc(input logic [5:0] op, input logic [4:0] rs,
                                        input logic [4:0] rt, input logic [15:0] imm);
        return {op, rs, rt, imm};
    endfunction

    function automatic dir_row_t row(input logic [31:0] ins, input logic [31:0] src,
                                     input logic [31:0] tgt, input logic [31:0] pc,
                                     input logic [31:0] ldw);
        dir_row_t d;
        d        = '0;
        d.cmd    = {ins, src, tgt, pc, ldw};
        return d;
    endfunction

    function automatic dir_row_t pin(input dir_row_t d, input exec_res_t want);
        d.pinned = 1'b1;
        d.want   = want;
        return d;
    endfunction

    // Result of a faulting instruction: only address, target and code survive
    function automatic exec_res_t faulted(input logic [31:0] addr,
                                          input logic [31:0] target, input fault_t f);
        exec_res_t r;
        r        = '0;
        r.addr   = addr;
        r.target = target;
        r.fault  = f;
        return r;
    endfunction

    function automatic logic [31:0] operand_value();
        case ($urandom_range(9))
            0:       return 32'h0000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Mostly well-formed instructions; loads and stores usually land in or
    // right beside a readable region so the lane logic gets exercised.
    function automatic cmd_t random_command();
        cmd_t        c;
        logic [5:0]  op;
        logic [4:0]  rs;
        logic [4:0]  rt;
        logic [15:0] imm;
        logic [31:0] ea;
        logic [31:0] r;

        c.src = operand_value();
        c.tgt = operand_value();
        c.pc  = operand_value();
        c.ldw = $urandom;
        r     = $urandom;
        rs    = r[4:0];
        rt    = r[9:5];
        imm   = r[31:16];
        if ($urandom_range(99) < 6)
            op = r[15:10];
        else
            op = known_ops[$urandom_range(22)];

        case (op)
            OP_REGIMM:
                if ($urandom_range(9) != 0)
                    case ($urandom_range(3))
                        0:       rt = RT_BLTZ;
                        1:       rt = RT_BGEZ;
                        2:       rt = RT_BLTZAL;
                        default: rt = RT_BGEZAL;
                    endcase
            OP_BGTZ, OP_BLEZ:
                if ($urandom_range(9) != 0)
                    rt = 5'd0;
            OP_LUI:
                if ($urandom_range(9) != 0)
                    rs = 5'd0;
            OP_BEQ, OP_BNE:
                if ($urandom_range(1) != 0)
                    c.tgt = c.src;
            OP_LB, OP_LBU, OP_LH, OP_LHU, OP_LW, OP_LWL, OP_LWR, OP_SB, OP_SH, OP_SW:
                if ($urandom_range(9) != 0)
                begin
                    r = $urandom;
                    case ($urandom_range(5))
                        0: ea = RAM_LO | {6'd0, r[25:0]};
                        1: ea = ROM_LO | {8'd0, r[23:0]};
                        2: ea = IO_WORD | {30'd0, r[1:0]};
                        3: ea = (r[31] ? RAM_LO : RAM_HI) - 32'd4 + {30'd0, r[1:0]};
                        4: ea = (r[31] ? ROM_LO : ROM_HI) - 32'd4 + {30'd0, r[1:0]};
                        default:
                           ea = (r[31] ? IO_WORD + 32'd4 : RAM_HI) + {30'd0, r[1:0]};
                    endcase
                    if ($urandom_range(4) != 0)
                    begin
                        if (op == OP_LW || op == OP_SW)
                            ea[1:0] = 2'b00;
                        else if (op == OP_LH || op == OP_LHU || op == OP_SH)
                            ea[0] = 1'b0;
                    end
                    c.src = ea - {{16{imm[15]}}, imm};
                end
            default: ;
        endcase
        c.instr = enc(op, rs, rt, imm);
        return c;
    endfunction

    task automatic report_error(input string msg);
        error_count++;
        $display("%0t ns  ERROR  %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_error($sformatf("result %0d %s: got %h, want %h",
                                   results_seen, name, got, want));
    endtask

    // -----------------------------------------------------------------------
    // Command side. Called at a falling edge; returns at the falling edge
    // after the transfer. While idle, the payload carries junk so that the
    // unit is seen to ignore it without start.
    // -----------------------------------------------------------------------
    task automatic send_command(input cmd_t c, input logic pinned, input exec_res_t want);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            start     = 1'b0;
            pin_valid = 1'b0;
            {instr_word, src_value, tgt_value, slot_pc, load_word} =
                {$urandom, $urandom, $urandom, $urandom, $urandom};
            @(negedge clk);
        end
        start     = 1'b1;
        pin_valid = pinned;
        pin_res   = want;
        {instr_word, src_value, tgt_value, slot_pc, load_word} = c;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
    endtask

    // -----------------------------------------------------------------------
    // Scoreboard. On each rising edge, first score a result that is leaving,
    // then log the expectation for a command being transferred. Doing both
    // in one process keeps the queue order independent of scheduling.
    // -----------------------------------------------------------------------
    always @(posedge clk)
    begin
        exec_res_t want;
        if (rst_n)
        begin
            if (done)
            begin
                results_seen++;
                if (pending_results.size() == 0)
                    report_error($sformatf("result %0d with nothing outstanding",
                                           results_seen));
                else
                begin
                    want = pending_results.pop_front();
                    check_field("wb_enable",     32'(wb_enable),     32'(want.wb_en));
                    check_field("wb_index",      32'(wb_index),      32'(want.wb_idx));
                    check_field("wb_value",      wb_value,           want.wb_val);
                    check_field("store_enable",  32'(store_enable),  32'(want.st_en));
                    check_field("mem_addr",      mem_addr,           want.addr);
                    check_field("store_data",    store_data,         want.st_data);
                    check_field("byte_mask",     32'(byte_mask),     32'(want.mask));
                    check_field("branch_taken",  32'(branch_taken),  32'(want.taken));
                    check_field("branch_target", branch_target,      want.target);
                    check_field("fault_code",    32'(fault_code),    32'(want.fault));
                end
            end
            if (start && !busy)
                pending_results.push_back(pin_valid ? pin_res :
                    execute_immediate({instr_word, src_value, tgt_value, slot_pc, load_word}));
        end
    end

    // -----------------------------------------------------------------------
    // Main sequence
    // -----------------------------------------------------------------------
    initial
    begin
        int waited;

        rst_n           = 1'b0;
        start           = 1'b0;
        pin_valid       = 1'b0;
        pin_res         = '0;
        instr_word      = 32'd0;
        src_value       = 32'd0;
        tgt_value       = 32'd0;
        slot_pc         = 32'd0;
        load_word       = 32'd0;
        sender_idle_pct = 32;
        error_count     = 0;
        results_seen    = 0;
        known_ops       = '{OP_REGIMM, OP_BEQ, OP_BNE, OP_BLEZ, OP_BGTZ, OP_ADDI, OP_ADDIU,
                            OP_SLTI, OP_SLTIU, OP_ANDI, OP_ORI, OP_XORI, OP_LUI,
                            OP_LB, OP_LH, OP_LWL, OP_LW, OP_LBU, OP_LHU, OP_LWR,
                            OP_SB, OP_SH, OP_SW};

        // Faults, with the result written out by hand
        stimulus_table.push_back(pin(row(enc(OP_ADDI, 5'd1, 5'd2, 16'h0001),
            32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0), faulted(32'h0, 32'h0, FAULT_OVERFLOW)));
        stimulus_table.push_back(pin(row(enc(OP_UNUSED, 5'd31, 5'd31, 16'hFFFF),
            32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF),
            faulted(32'h0, 32'h0, FAULT_UNKNOWN)));
        stimulus_table.push_back(pin(row(enc(OP_REGIMM, 5'd1, RT_UNUSED, 16'h0010),
            32'h8000_0000, 32'h0, 32'h0000_1000, 32'h0), faulted(32'h0, 32'h0, FAULT_UNKNOWN)));
        stimulus_table.push_back(pin(row(enc(OP_LUI, 5'd1, 5'd7, 16'h1234),
            32'h0, 32'h0, 32'h0, 32'h0), faulted(32'h0, 32'h0, FAULT_RESERVED)));
        stimulus_table.push_back(pin(row(enc(OP_BGTZ, 5'd2, 5'd1, 16'h0004),
            32'h0000_0001, 32'h0, 32'h0000_1000, 32'h0),
            faulted(32'h0, 32'h0000_1010, FAULT_RESERVED)));
        stimulus_table.push_back(pin(row(enc(OP_LW, 5'd1, 5'd2, 16'h0001),
            RAM_LO, 32'h0, 32'h0, 32'h1234_5678), faulted(32'h2000_0001, 32'h0, FAULT_ALIGN)));
        stimulus_table.push_back(pin(row(enc(OP_SH, 5'd1, 5'd2, 16'h0001),
            RAM_LO, 32'hFFFF_FFFF, 32'h0, 32'h0), faulted(32'h2000_0001, 32'h0, FAULT_ALIGN)));
        // just below RAM: readable neither as RAM nor as ROM
        stimulus_table.push_back(pin(row(enc(OP_LB, 5'd1, 5'd2, 16'hFFFF),
            RAM_LO, 32'h0, 32'h0, 32'hFFFF_FFFF), faulted(32'h1FFF_FFFF, 32'h0, FAULT_RANGE)));

        // Operations except ADDI and SH at field extremes, scored by the model
        stimulus_table.push_back(row(enc(OP_ANDI, 5'd31, 5'd31, 16'hFFFF),
            32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0));
        stimulus_table.push_back(row(enc(OP_ORI, 5'd0, 5'd1, 16'h8000),
            32'h0, 32'h0, 32'h0, 32'h0));
        stimulus_table.push_back(row(enc(OP_XORI, 5'd1, 5'd0, 16'hFFFF),
            32'hAAAA_5555, 32'h0, 32'h0, 32'h0));
        stimulus_table.push_back(row(enc(OP_SLTI, 5'd2, 5'd3, 16'h0000),
            32'h8000_0000, 32'h0, 32'h0, 32'h0));
        stimulus_table.push_back(row(enc(OP_SLTIU, 5'd2, 5'd3, 16'hFFFF),
            32'hFFFF_FFFE, 32'h0, 32'h0, 32'h0));
        stimulus_table.push_back(row(enc(OP_ADDIU, 5'd4, 5'd5, 16'h8000),
            32'h8000_0000, 32'h0, 32'h0, 32'h0));
        stimulus_table.push_back(row(enc(OP_LUI, 5'd0, 5'd31, 16'hFFFF),
            32'h0, 32'h0, 32'h0, 32'h0));
        stimulus_table.push_back(row(enc(OP_BEQ, 5'd1, 5'd2, 16'h7FFF),
            32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFC, 32'h0));
        stimulus_table.push_back(row(enc(OP_BNE, 5'd1, 5'd2, 16'h8000),
            32'h0000_0001, 32'h0, 32'h0, 32'h0));
        stimulus_table.push_back(row(enc(OP_BLEZ, 5'd1, 5'd0, 16'h0001),
            32'h0, 32'h0, 32'h0000_0100, 32'h0));
        stimulus_table.push_back(row(enc(OP_BGTZ, 5'd1, 5'd0, 16'hFFFE),
            32'h0000_0001, 32'h0, 32'h0000_0100, 32'h0));
        stimulus_table.push_back(row(enc(OP_REGIMM, 5'd1, RT_BLTZ, 16'h0010),
            32'hFFFF_FFFF, 32'h0, 32'h0000_0200, 32'h0));
        stimulus_table.push_back(row(enc(OP_REGIMM, 5'd1, RT_BGEZ, 16'h0010),
            32'h0, 32'h0, 32'h0000_0200, 32'h0));
        // linking branch, not taken: r31 is written all the same
        stimulus_table.push_back(row(enc(OP_REGIMM, 5'd1, RT_BLTZAL, 16'hFFFF),
            32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFC, 32'h0));
        stimulus_table.push_back(row(enc(OP_REGIMM, 5'd1, RT_BGEZAL, 16'h0001),
            32'h0, 32'h0, 32'h0040_0000, 32'h0));
        stimulus_table.push_back(row(enc(OP_LB, 5'd1, 5'd2, 16'h0003),
            32'h23FF_FFFC, 32'h0, 32'h0, 32'h0000_00FF));
        stimulus_table.push_back(row(enc(OP_LBU, 5'd1, 5'd2, 16'h0000),
            ROM_LO, 32'h0, 32'h0, 32'h8000_0000));
        stimulus_table.push_back(row(enc(OP_LH, 5'd1, 5'd2, 16'h0002),
            RAM_LO, 32'h0, 32'h0, 32'h0000_8001));
        stimulus_table.push_back(row(enc(OP_LHU, 5'd1, 5'd2, 16'hFFFE),
            32'h1000_0002, 32'h0, 32'h0, 32'hFFFF_0000));
        stimulus_table.push_back(row(enc(OP_LW, 5'd1, 5'd9, 16'h0000),
            IO_WORD, 32'h0, 32'h0, 32'hDEAD_BEEF));
        stimulus_table.push_back(row(enc(OP_LWL, 5'd1, 5'd2, 16'h0001),
            RAM_LO, 32'hAABB_CCDD, 32'h0, 32'h1122_3344));
        stimulus_table.push_back(row(enc(OP_LWR, 5'd1, 5'd2, 16'h0002),
            32'h10FF_FFFC, 32'hAABB_CCDD, 32'h0, 32'h1122_3344));
        stimulus_table.push_back(row(enc(OP_SB, 5'd1, 5'd2, 16'h0001),
            32'h0, 32'h1234_56AB, 32'h0, 32'h0));
        stimulus_table.push_back(row(enc(OP_SW, 5'd1, 5'd2, 16'hFFFC),
            32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0));

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (stimulus_table[i])
            send_command(stimulus_table[i].cmd, stimulus_table[i].pinned,
                         stimulus_table[i].want);

        // Random part: sender idles about a third of the time, then half,
        // then runs back to back
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            sender_idle_pct = (n < RANDOM_ITEMS / 3)     ? 32 :
                              (n < 2 * RANDOM_ITEMS / 3) ? 50 : 0;
            send_command(random_command(), 1'b0, '0);
        end

        start     = 1'b0;
        pin_valid = 1'b0;
        for (waited = 0; pending_results.size() != 0 && waited < DRAIN_LIMIT; waited++)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);

        if (pending_results.size() != 0)
            report_error($sformatf("%0d results never arrived", pending_results.size()));

        if (error_count == 0)
            $display("tb_risc_immediate_execute_unit: clean");
        else
            $display("tb_risc_immediate_execute_unit: errors");
        $finish;
    end

    // Watchdog: stops a run that hangs
    initial
    begin
        #2_000_000;
        $display("watchdog expired at %0t ns", $realtime);
        $display("tb_risc_immediate_execute_unit: errors");
        $finish;
    end

endmodule
